/* src/mgi_pkg.sv */
// package for the multilinear grid interpolator: constants and codes
`timescale 1ns / 1ps
package mgi_pkg;
  localparam int FRAC_BITS = 16;
  localparam int GRID_BITS = 4;
  localparam int ADDR_W = 3 * GRID_BITS;
  localparam int NUM_CORNERS = 8;
  localparam int POS_W = 57;
  localparam int PROD_W = 50;
  localparam int SUM_W = 52;

  localparam logic [GRID_BITS-1:0] LAST_IDX = '1;
  localparam logic [23:0] INV_STEP_RST = 24'd65536;
  localparam logic [16:0] WT_ONE = 17'h10000;
  localparam logic [33:0] WT_HALF = 34'h8000;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_INV_STEP_X = 3'd3;
  localparam logic [2:0] CFG_INV_STEP_Y = 3'd4;
  localparam logic [2:0] CFG_INV_STEP_Z = 3'd5;
  localparam logic [2:0] CFG_PERIODIC = 3'd6;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [1:0] ST_INSIDE = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_ABOVE = 2'd2;
endpackage

/* src/multilinear_grid_interpolator_core.sv */
// top level of the multilinear grid interpolator: trilinear blend over a 16x16x16 grid
`timescale 1ns / 1ps
// usage
//   in_*: one word per item; in_tuser is the kind (0 store a sample, 1 evaluate).
//   a store writes one grid entry and gives no result; an evaluate gives one
//   result word on out_* with the interpolated value and per-axis status.
//   cfg_*: register writes, taken at any edge with cfg_we high; write them only
//   while the block is idle.
// timing
//   nine register stages from in to out. one word enters per cycle while the
//   output is not stalled; the eight corner samples are read in the same cycle
//   from eight copies of the grid memory, each written by every store.
// reset
//   rst_n clears valid bits and loads default registers; grid contents are
//   undefined until written.
// stall
//   when out_tvalid is high and out_tready low the whole pipeline holds and
//   in_tready drops; nothing is lost or repeated.
module multilinear_grid_interpolator_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // write_index, write_value, coord_x, coord_y, coord_z, zero pad
  input  logic [143:0] in_tdata,
  // kind
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // value, status_x, status_y, status_z, zero pad
  output logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int GB = mgi_pkg::GRID_BITS;
  localparam int NC = mgi_pkg::NUM_CORNERS;

  logic [31:0] origin_r [3];
  logic [23:0] inv_step_r [3];
  logic        periodic_r;

  logic adv;
  logic [7:0] v_r;
  logic out_valid_r;

  // stage 0
  logic              kind0_r;
  logic [mgi_pkg::ADDR_W-1:0] widx0_r;
  logic [31:0]       wval0_r;
  logic [32:0]       diff0_r [3];
  // stage 1
  logic              kind1_r;
  logic [mgi_pkg::ADDR_W-1:0] widx1_r;
  logic [31:0]       wval1_r;
  logic [mgi_pkg::POS_W-1:0] p1_r [3];
  logic [2:0]        neg1_r;
  // stage 2
  logic              kind2_r;
  logic [mgi_pkg::ADDR_W-1:0] widx2_r;
  logic [31:0]       wval2_r;
  logic [GB-1:0]     idx2_r [3];
  logic [15:0]       wt2_r [3];
  logic [1:0]        st2_r [3];
  // stage 3
  logic              kind3_r;
  logic [mgi_pkg::ADDR_W-1:0] widx3_r;
  logic [31:0]       wval3_r;
  logic [16:0]       wxy3_r [4];
  logic [16:0]       wzlo3_r, wzhi3_r;
  logic [mgi_pkg::ADDR_W-1:0] addr3_r [NC];
  logic [1:0]        st3_r [3];
  // stage 4
  logic              kind4_r;
  logic [31:0]       rd4_r [NC];
  logic [16:0]       w4_r [NC];
  logic [1:0]        st4_r [3];
  // stage 5
  logic              kind5_r;
  logic [mgi_pkg::PROD_W-1:0] prod5_r [NC];
  logic [1:0]        st5_r [3];
  // stage 6
  logic              kind6_r;
  logic [mgi_pkg::SUM_W-1:0] sum6_r [4];
  logic [1:0]        st6_r [3];
  // stage 7
  logic              kind7_r;
  logic [mgi_pkg::SUM_W-1:0] sum7_r;
  logic [1:0]        st7_r [3];
  // output
  logic [31:0]       val_r;
  logic [1:0]        sto_r [3];

  assign adv = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {2'b00, sto_r[2], sto_r[1], sto_r[0], val_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        origin_r[a] <= '0;
        inv_step_r[a] <= mgi_pkg::INV_STEP_RST;
      end
      periodic_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mgi_pkg::CFG_ORIGIN_X:   origin_r[0] <= cfg_wdata;
        mgi_pkg::CFG_ORIGIN_Y:   origin_r[1] <= cfg_wdata;
        mgi_pkg::CFG_ORIGIN_Z:   origin_r[2] <= cfg_wdata;
        mgi_pkg::CFG_INV_STEP_X: inv_step_r[0] <= cfg_wdata[23:0];
        mgi_pkg::CFG_INV_STEP_Y: inv_step_r[1] <= cfg_wdata[23:0];
        mgi_pkg::CFG_INV_STEP_Z: inv_step_r[2] <= cfg_wdata[23:0];
        mgi_pkg::CFG_PERIODIC:   periodic_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r <= {v_r[6:0], in_tvalid};
      out_valid_r <= v_r[7] && (kind7_r == mgi_pkg::KIND_EVAL);
    end
  end

  // grid position per axis
  logic [mgi_pkg::POS_W-1:0] p_nxt [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [mgi_pkg::POS_W-1:0] pm;
      pm = $signed(diff0_r[a]) * $signed({1'b0, inv_step_r[a]});
      p_nxt[a] = pm;
    end
  end

  // axis classification
  logic [GB-1:0] idx_nxt [3];
  logic [15:0]   wt_nxt [3];
  logic [1:0]    st_nxt [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [24:0] ip;
      logic [31:0] fr;
      ip = p1_r[a][56:32];
      fr = p1_r[a][31:0];
      idx_nxt[a] = ip[GB-1:0];
      wt_nxt[a] = fr[31:16];
      st_nxt[a] = mgi_pkg::ST_INSIDE;
      if (!periodic_r) begin
        if (neg1_r[a]) begin
          idx_nxt[a] = '0;
          wt_nxt[a] = '0;
          st_nxt[a] = mgi_pkg::ST_BELOW;
        end else if ((|ip[24:GB]) ||
                     (ip[GB-1:0] == mgi_pkg::LAST_IDX && fr != '0)) begin
          idx_nxt[a] = mgi_pkg::LAST_IDX;
          wt_nxt[a] = '0;
          st_nxt[a] = mgi_pkg::ST_ABOVE;
        end
      end
    end
  end

  // xy weights and corner addresses
  logic [16:0] wxy_nxt [4];
  logic [mgi_pkg::ADDR_W-1:0] addr_nxt [NC];
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [16:0] wx, wy;
      logic [33:0] m;
      wx = j[0] ? {1'b0, wt2_r[0]} : mgi_pkg::WT_ONE - {1'b0, wt2_r[0]};
      wy = j[1] ? {1'b0, wt2_r[1]} : mgi_pkg::WT_ONE - {1'b0, wt2_r[1]};
      m = wx * wy + mgi_pkg::WT_HALF;
      wxy_nxt[j] = m[32:16];
    end
    for (int c = 0; c < NC; c++) begin
      addr_nxt[c] = {idx2_r[0] + GB'(c & 1), idx2_r[1] + GB'((c >> 1) & 1),
                     idx2_r[2] + GB'((c >> 2) & 1)};
    end
  end

  // full corner weights, products, reduction, rounding, saturation
  logic [16:0] w_nxt [NC];
  logic [mgi_pkg::PROD_W-1:0] prod_nxt [NC];
  logic [mgi_pkg::SUM_W-1:0] sum6_nxt [4];
  logic [mgi_pkg::SUM_W-1:0] sum7_nxt;
  logic [31:0] val_nxt;
  always_comb begin
    logic [mgi_pkg::SUM_W-1:0] rnd;
    logic [35:0] res;
    for (int c = 0; c < NC; c++) begin
      logic [33:0] m;
      logic signed [mgi_pkg::PROD_W-1:0] pr;
      m = wxy3_r[c % 4] * (c >= 4 ? wzhi3_r : wzlo3_r) + mgi_pkg::WT_HALF;
      w_nxt[c] = m[32:16];
      pr = $signed(rd4_r[c]) * $signed({1'b0, w4_r[c]});
      // a corner with zero weight adds nothing
      prod_nxt[c] = (w4_r[c] == '0) ? '0 : pr;
    end
    for (int k = 0; k < 4; k++) begin
      sum6_nxt[k] = {{2{prod5_r[2*k][mgi_pkg::PROD_W-1]}}, prod5_r[2*k]} +
                    {{2{prod5_r[2*k+1][mgi_pkg::PROD_W-1]}}, prod5_r[2*k+1]};
    end
    sum7_nxt = sum6_r[0] + sum6_r[1] + sum6_r[2] + sum6_r[3];
    rnd = sum7_r + mgi_pkg::SUM_W'(mgi_pkg::WT_HALF);
    res = rnd[mgi_pkg::SUM_W-1:16];
    if ($signed(res) > $signed(36'sh07FFFFFFF)) val_nxt = 32'h7FFFFFFF;
    else if ($signed(res) < $signed(-36'sh080000000)) val_nxt = 32'h80000000;
    else val_nxt = res[31:0];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      kind0_r <= in_tuser;
      widx0_r <= in_tdata[11:0];
      wval0_r <= in_tdata[43:12];
      for (int a = 0; a < 3; a++) begin
        diff0_r[a] <= {in_tdata[44+32*a+31], in_tdata[44+32*a +: 32]} -
                      {origin_r[a][31], origin_r[a]};
      end

      kind1_r <= kind0_r;
      widx1_r <= widx0_r;
      wval1_r <= wval0_r;
      for (int a = 0; a < 3; a++) begin
        p1_r[a] <= p_nxt[a];
        neg1_r[a] <= diff0_r[a][32];
      end

      kind2_r <= kind1_r;
      widx2_r <= widx1_r;
      wval2_r <= wval1_r;
      idx2_r <= idx_nxt;
      wt2_r <= wt_nxt;
      st2_r <= st_nxt;

      kind3_r <= kind2_r;
      widx3_r <= widx2_r;
      wval3_r <= wval2_r;
      wxy3_r <= wxy_nxt;
      wzlo3_r <= mgi_pkg::WT_ONE - {1'b0, wt2_r[2]};
      wzhi3_r <= {1'b0, wt2_r[2]};
      addr3_r <= addr_nxt;
      st3_r <= st2_r;

      kind4_r <= kind3_r;
      w4_r <= w_nxt;
      st4_r <= st3_r;

      kind5_r <= kind4_r;
      prod5_r <= prod_nxt;
      st5_r <= st4_r;

      kind6_r <= kind5_r;
      sum6_r <= sum6_nxt;
      st6_r <= st5_r;

      kind7_r <= kind6_r;
      sum7_r <= sum7_nxt;
      st7_r <= st6_r;

      val_r <= val_nxt;
      sto_r <= st7_r;
    end
  end

  // one grid copy per corner, each written by every store
  for (genvar c = 0; c < NC; c++) begin : g_bank
    logic [31:0] mem [1 << mgi_pkg::ADDR_W];
    always_ff @(posedge clk) begin
      if (adv) begin
        if (v_r[3] && kind3_r == mgi_pkg::KIND_WRITE) mem[widx3_r] <= wval3_r;
        rd4_r[c] <= mem[addr3_r[c]];
      end
    end
  end

endmodule

/* tb/sv/multilinear_grid_interpolator_core_test.sv */
// testbench for the multilinear grid interpolator: directed and random stores and evaluations vs a predictor
`timescale 1ns / 1ps
module multilinear_grid_interpolator_core_test;

  typedef struct packed {
    logic [1:0]  sz;
    logic [1:0]  sy;
    logic [1:0]  sx;
    logic [31:0] value;
  } interp_word_t;

  class interp_scoreboard;
    interp_word_t pending[$];
    int errors;
    function new();
      errors = 0;
    endfunction
    function void note_eval(interp_word_t w);
      pending.push_back(w);
    endfunction
    function void check_word(interp_word_t got);
      interp_word_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) begin
        $display("%0t value: expected %h actual %h", $time, want.value, got.value);
        errors++;
      end
      if (got.sx !== want.sx) begin
        $display("%0t status_x: expected %0d actual %0d", $time, want.sx, got.sx);
        errors++;
      end
      if (got.sy !== want.sy) begin
        $display("%0t status_y: expected %0d actual %0d", $time, want.sy, got.sy);
        errors++;
      end
      if (got.sz !== want.sz) begin
        $display("%0t status_z: expected %0d actual %0d", $time, want.sz, got.sz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [39:0] out_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  multilinear_grid_interpolator_core uut (.*);

  always #4 clk = ~clk;

  interp_scoreboard sb = new();
  longint origin_q[3];
  longint inv_step_q[3];
  bit wrap_mode;
  logic signed [31:0] grid_mem[4096];
  bit grid_written[4096];
  int unsigned corner_q[$];
  bit hold_off = 0;
  bit tx_done = 0;
  longint cycles = 0;

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  // also lists in corner_q the grid entries the evaluation reads, less upper corners on an axis of zero weight
  function automatic interp_word_t interpolate(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz);
    interp_word_t r;
    longint idx[3], wt[3], diff, p, ip, f, w, acc, res, i, addr;
    logic [1:0] st[3];
    logic [31:0] coord[3];
    bit skip;
    corner_q.delete();
    coord[0] = cx; coord[1] = cy; coord[2] = cz;
    acc = 0;
    for (int a = 0; a < 3; a++) begin
      idx[a] = 0; wt[a] = 0; st[a] = mgi_pkg::ST_INSIDE;
      diff = longint'($signed(coord[a])) - origin_q[a];
      p = diff * inv_step_q[a];
      ip = floor_div(p, 32);
      f = (p & 64'hFFFF_FFFF) >> 16;
      if (wrap_mode) begin
        idx[a] = ip & 15;
        wt[a] = f;
      end else if (diff < 0) begin
        st[a] = mgi_pkg::ST_BELOW;
      end else if (ip > 15 || (ip == 15 && (p & 64'hFFFF_FFFF) != 0)) begin
        st[a] = mgi_pkg::ST_ABOVE;
        idx[a] = 15;
      end else begin
        idx[a] = ip;
        wt[a] = f;
      end
    end
    for (int c = 0; c < 8; c++) begin
      w = 65536; addr = 0; skip = 0;
      for (int a = 0; a < 3; a++) begin
        i = idx[a];
        if (c[a]) begin
          if (wt[a] == 0) skip = 1;
          i = (i + 1) & 15;
          w = (w * wt[a] + 32768) >>> 16;
        end else begin
          w = (w * (65536 - wt[a]) + 32768) >>> 16;
        end
        addr = addr * 16 + i;
      end
      if (!skip) begin
        acc += longint'(grid_mem[addr & 4095]) * w;
        corner_q.push_back(32'(addr & 4095));
      end
    end
    res = floor_div(acc + 32768, 16);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.value = res[31:0];
    r.sx = st[0]; r.sy = st[1]; r.sz = st[2];
    return r;
  endfunction

  function automatic logic [31:0] rand_sample();
    return ($urandom_range(0, 3) == 0) ? $urandom :
           $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
  endfunction

  task automatic write_reg(logic [2:0] index, logic [31:0] data);
    cfg_we <= 1; cfg_index <= index; cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (index)
      mgi_pkg::CFG_ORIGIN_X, mgi_pkg::CFG_ORIGIN_Y, mgi_pkg::CFG_ORIGIN_Z:
        origin_q[index] = longint'($signed(data));
      mgi_pkg::CFG_INV_STEP_X, mgi_pkg::CFG_INV_STEP_Y, mgi_pkg::CFG_INV_STEP_Z:
        inv_step_q[index - 3] = data[23:0];
      mgi_pkg::CFG_PERIODIC: wrap_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
        ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (n > 0) begin
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // holds in_tvalid high while waiting, lowers only when a gap or a drain follows
  task automatic send_word(logic kind, logic [11:0] index, logic [31:0] data,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    in_tvalid <= 1; in_tuser <= kind;
    in_tdata <= {4'b0, cz, cy, cx, data, index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == mgi_pkg::KIND_WRITE) begin
      grid_mem[index] = $signed(data);
      grid_written[index] = 1;
    end else begin
      sb.note_eval(interpolate(cx, cy, cz));
    end
  endtask

  task automatic store(logic [11:0] index, logic [31:0] data);
    send_word(mgi_pkg::KIND_WRITE, index, data, $urandom, $urandom, $urandom);
  endtask

  // entries the evaluation reads are stored first if they were never written
  task automatic eval(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    void'(interpolate(cx, cy, cz));
    foreach (corner_q[k]) begin
      if (!grid_written[corner_q[k]]) store(12'(corner_q[k]), rand_sample());
    end
    send_word(mgi_pkg::KIND_EVAL, 12'($urandom), $urandom, cx, cy, cz);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int a);
    // mostly near the grid start, sometimes anywhere
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'(origin_q[a] + $urandom_range(0, 32'h0003_8000) - 32'h0000_8000);
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata[37:0]);
  end

  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      n = $urandom_range(0, 9);
      out_tready <= (n > 2) || tx_done;
      if (n == 0 && !tx_done) repeat ($urandom_range(5, 30)) @(posedge clk);
      else @(posedge clk);
    end
  end

  initial begin
    origin_q = '{0, 0, 0};
    inv_step_q = '{65536, 65536, 65536};
    wrap_mode = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // extremes at a few spots
    store(12'd0, 32'h7FFF_FFFF);
    store(12'd1, 32'h8000_0000);
    // directed evaluations in clamped mode
    eval(0, 0, 0);
    eval(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    eval(32'hFFFF_0000, 32'h0000_4000, 32'h0010_0000);
    eval(32'h000F_0000, 32'h000F_0001, 32'h000E_FFFF);
    eval(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    eval(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    store(12'd17, 32'h7FFF_FFFF);
    store(12'd273, 32'h7FFF_FFFF);
    eval(32'h0000_8000, 32'h0001_8000, 32'h0001_8000);
    drain();
    write_reg(mgi_pkg::CFG_PERIODIC, 32'd1);
    eval(32'hFFFF_8000, 32'h000F_8000, 32'h8000_0000);
    eval(32'h7FFF_FFFF, 32'h0123_4567, 32'hFEDC_BA98);
    drain();
    write_reg(mgi_pkg::CFG_INV_STEP_X, 32'd0);
    write_reg(mgi_pkg::CFG_INV_STEP_Y, 32'h00FF_FFFF);
    write_reg(mgi_pkg::CFG_INV_STEP_Z, 32'h0000_8000);
    write_reg(mgi_pkg::CFG_ORIGIN_X, 32'h8000_0000);
    write_reg(mgi_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(mgi_pkg::CFG_ORIGIN_Z, 32'hFFF0_0000);
    eval(0, 32'h8000_0000, 32'h7FFF_FFFF);
    eval(32'h1234_5678, 32'h7FFF_0000, 0);
    drain();
    // random phases with changing settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(mgi_pkg::CFG_PERIODIC, {31'b0, ph[0]});
      for (int a = 0; a < 3; a++) begin
        write_reg(3'(mgi_pkg::CFG_ORIGIN_X + a),
                  (ph == 5) ? 32'h7FFF_FFFF :
                  $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        write_reg(3'(mgi_pkg::CFG_INV_STEP_X + a),
                  (ph == 4) ? 32'h00FF_FFFF : $urandom_range(32'h4000, 32'h1_8000));
      end
      if (ph == 2) hold_off = 1;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 4) == 0)
          store(12'($urandom), $urandom);
        else
          eval(rand_coord(0), rand_coord(1), rand_coord(2));
        random_gap();
      end
      drain();
    end
    tx_done = 1;
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
